/* sv/pud_pkg.sv */
// Shared types and constants for the URL percent decoder.
package pud_pkg;

    // Most result items one input item can cause.
    localparam int MAX_RESULTS = 3;

    // One input item: a raw byte and its end-of-string flag.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       string_end;
        logic       run_end;
    } out_item_t;

    // All result items caused by one input item, in order, with their count.
    typedef struct packed {
        logic [1:0]                        count;
        out_item_t [MAX_RESULTS-1:0]       items;
    } result_group_t;

endpackage

/* sv/pud_stream_if.sv */
// Valid/ready stream channel carrying one item of a given payload type.
interface pud_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/pud_decode.sv */
// Percent-sequence scanner: holds the scan state and forms the results of one item.
module pud_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pud_pkg::in_item_t      item,
    input  logic                   fire,
    output pud_pkg::result_group_t group
);
    import pud_pkg::*;

    localparam logic [7:0] PCT_CHAR        = 8'h25;
    localparam logic [7:0] NO_DECODE_VALUE = 8'h7F;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    logic [7:0] res_bytes [4];
    logic [1:0] res_count;
    logic       reprocess;
    logic       cur_hex;

    // True for 0-9, A-F and a-f.
    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Digit value of a byte already known to be a hex digit.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c[6])
        begin
            v = c[3:0] + 4'd9;
        end
        else
        begin
            v = c[3:0];
        end
        hex_val = v;
    endfunction

    assign cur_hex = is_hex(item.in_byte);

    // Scan step: build the ordered result bytes and the next phase.
    always_comb
    begin
        res_bytes  = '{default: 8'h00};
        res_count  = 2'd0;
        reprocess  = 1'b0;
        phase_next = phase_reg;
        held_next  = held_reg;

        unique case (phase_reg)
            PH_PCT:
            begin
                if (cur_hex)
                begin
                    held_next  = item.in_byte;
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    res_bytes[0] = PCT_CHAR;
                    res_count    = 2'd1;
                    phase_next   = PH_IDLE;
                    reprocess    = 1'b1;
                end
            end
            PH_DIGIT:
            begin
                phase_next = PH_IDLE;
                if (cur_hex)
                begin
                    if ({hex_val(held_reg), hex_val(item.in_byte)} != NO_DECODE_VALUE)
                    begin
                        res_bytes[0] = {hex_val(held_reg), hex_val(item.in_byte)};
                        res_count    = 2'd1;
                    end
                    else
                    begin
                        // The encoded DEL value is passed through as received.
                        res_bytes[0] = PCT_CHAR;
                        res_bytes[1] = held_reg;
                        res_bytes[2] = item.in_byte;
                        res_count    = 2'd3;
                    end
                end
                else
                begin
                    res_bytes[0] = PCT_CHAR;
                    res_bytes[1] = held_reg;
                    res_count    = 2'd2;
                    reprocess    = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                reprocess  = 1'b1;
            end
        endcase

        // Handle the byte as if it arrived while idle.
        if (reprocess)
        begin
            if (item.in_byte == PCT_CHAR)
            begin
                phase_next = PH_PCT;
            end
            else
            begin
                res_bytes[res_count] = item.in_byte;
                res_count            = res_count + 2'd1;
            end
        end

        // End of string flushes whatever is still held.
        if (item.is_last)
        begin
            if (phase_next == PH_PCT)
            begin
                res_bytes[res_count] = PCT_CHAR;
                res_count            = res_count + 2'd1;
            end
            else if (phase_next == PH_DIGIT)
            begin
                res_bytes[res_count] = PCT_CHAR;
                res_count            = res_count + 2'd1;
                res_bytes[res_count] = held_next;
                res_count            = res_count + 2'd1;
            end
            phase_next = PH_IDLE;
        end
    end

    // Attach the flags to the last result of the item.
    always_comb
    begin
        group.count = res_count;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            group.items[i].out_byte   = res_bytes[i];
            group.items[i].run_end    = (2'(i) + 2'd1 == res_count);
            group.items[i].string_end = (2'(i) + 2'd1 == res_count) && item.is_last;
        end
    end

    // Scan phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
        end
    end

    // Held hex digit.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            held_reg <= held_next;
        end
    end

endmodule

/* sv/pud_result_fifo.sv */
// Result queue: up to three items in at once, one per cycle out while out_ready.
module pud_result_fifo #(
    parameter int DEPTH_LOG2 = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  pud_pkg::result_group_t group,
    output logic                   space_ok,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pud_pkg::out_item_t     out_item
);
    import pud_pkg::*;

    localparam int DEPTH = 1 << DEPTH_LOG2;
    localparam int CNT_W = DEPTH_LOG2 + 1;

    out_item_t             mem_reg [DEPTH];
    logic [DEPTH_LOG2-1:0] wr_ptr_reg, wr_ptr_next;
    logic [DEPTH_LOG2-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [1:0]            push_n;
    logic                  pop;

    assign push_n    = push ? group.count : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign space_ok  = (count_reg <= CNT_W'(DEPTH - MAX_RESULTS));

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + DEPTH_LOG2'(push_n);
        rd_ptr_next = rd_ptr_reg + DEPTH_LOG2'(pop);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the new result items in order at the write pointer.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (2'(i) < push_n)
            begin
                mem_reg[wr_ptr_reg + DEPTH_LOG2'(i)] <= group.items[i];
            end
        end
    end

endmodule

/* sv/url_percent_decoder_top.sv */
// Top level of the URL percent decoder.
//
//  channel  | dir | payload                          | handshake
//  in_ch    | in  | in_byte[7:0], is_last            | valid/ready
//  out_ch   | out | out_byte[7:0], string_end, run_end | valid/ready
//
// An item is scanned in the cycle it is accepted; its zero to three results enter
// the result queue at that edge and leave on out_ch in order, one per cycle while
// out_ch.ready is high, so the queue drain port sets the output rate. One input
// item per cycle is taken while the queue has room for three results.
// Reset (rst_n low) returns the scanner to idle and empties the queue.
module url_percent_decoder_top #(
    parameter int QUEUE_DEPTH_LOG2 = 3
) (
    input logic         clk,
    input logic         rst_n,
    pud_stream_if.sink   in_ch,
    pud_stream_if.source out_ch
);
    import pud_pkg::*;

    result_group_t group;
    logic          space_ok;
    logic          fire;

    assign in_ch.ready = space_ok;
    assign fire        = in_ch.valid && space_ok;

    // Scanner.
    pud_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (in_ch.data),
        .fire  (fire),
        .group (group)
    );

    // Result queue.
    pud_result_fifo #(
        .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .group     (group),
        .space_ok  (space_ok),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_ch.data)
    );

endmodule

/* sim/pud_decode_checker.sv */
// Predicts and checks the decoded byte stream of the URL percent decoder.
module pud_decode_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  pud_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  pud_pkg::out_item_t out_data,
    output int                 fail_count,
    output int                 pending_results,
    output int                 items_taken,
    output int                 results_checked,
    output int                 escapes_decoded
);
    timeunit 1ns;
    timeprecision 1ps;

    import pud_pkg::*;

    localparam logic [7:0] PERCENT   = 8'h25;
    localparam logic [7:0] NO_DECODE = 8'h7F;

    // Scanner phases; the fourth code is never entered and reads as idle.
    typedef enum logic [1:0] {
        SCAN_IDLE  = 2'd0,
        SCAN_PCT   = 2'd1,
        SCAN_DIGIT = 2'd2
    } scan_phase_t;

    scan_phase_t phase;
    logic [7:0]  held_digit;
    out_item_t   awaited[$];

    // Value of an ASCII hex digit, or -1 for any other byte.
    function automatic int hex_digit_value(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    function automatic out_item_t plain_result(logic [7:0] b);
        out_item_t r;
        r.out_byte   = b;
        r.string_end = 1'b0;
        r.run_end    = 1'b0;
        return r;
    endfunction

    // Scan one accepted byte and queue the results it causes.
    task automatic decode_step(in_item_t it);
        out_item_t  run[$];
        logic [7:0] b;
        logic [7:0] code;
        int         lo;
        int         hi;
        bit         rescan;
        b      = it.in_byte;
        lo     = hex_digit_value(b);
        rescan = 1'b0;
        case (phase)
            SCAN_PCT:
            begin
                if (lo >= 0)
                begin
                    held_digit = b;
                    phase      = SCAN_DIGIT;
                end
                else
                begin
                    run.push_back(plain_result(PERCENT));
                    phase  = SCAN_IDLE;
                    rescan = 1'b1;
                end
            end
            SCAN_DIGIT:
            begin
                if (lo >= 0)
                begin
                    hi   = hex_digit_value(held_digit);
                    code = 8'(hi * 16 + lo);
                    if (code != NO_DECODE)
                    begin
                        run.push_back(plain_result(code));
                        escapes_decoded++;
                    end
                    else
                    begin
                        // The encoded DEL byte passes through as three raw bytes.
                        run.push_back(plain_result(PERCENT));
                        run.push_back(plain_result(held_digit));
                        run.push_back(plain_result(b));
                    end
                    phase = SCAN_IDLE;
                end
                else
                begin
                    run.push_back(plain_result(PERCENT));
                    run.push_back(plain_result(held_digit));
                    phase  = SCAN_IDLE;
                    rescan = 1'b1;
                end
            end
            default:
            begin
                phase  = SCAN_IDLE;
                rescan = 1'b1;
            end
        endcase

        // A byte that broke an escape is handled as if the scanner were idle.
        if (rescan)
        begin
            if (b == PERCENT)
                phase = SCAN_PCT;
            else
                run.push_back(plain_result(b));
        end

        // End of string flushes whatever is still held.
        if (it.is_last)
        begin
            if (phase == SCAN_PCT)
            begin
                run.push_back(plain_result(PERCENT));
            end
            else if (phase == SCAN_DIGIT)
            begin
                run.push_back(plain_result(PERCENT));
                run.push_back(plain_result(held_digit));
            end
            phase = SCAN_IDLE;
        end

        if (run.size() > 0)
        begin
            run[run.size()-1].run_end = 1'b1;
            if (it.is_last)
                run[run.size()-1].string_end = 1'b1;
        end
        foreach (run[i])
            awaited.push_back(run[i]);
    endtask

    // Compare one delivered result with the oldest awaited one.
    task automatic compare_result(out_item_t got);
        out_item_t want;
        if (awaited.size() == 0)
        begin
            $error("unexpected result item: out_byte=%02h string_end=%0b run_end=%0b",
                   got.out_byte, got.string_end, got.run_end);
            fail_count++;
            return;
        end
        want = awaited.pop_front();
        results_checked++;
        if (got.out_byte !== want.out_byte)
        begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
            fail_count++;
        end
        if (got.string_end !== want.string_end)
        begin
            $error("string_end: expected %0b, got %0b", want.string_end, got.string_end);
            fail_count++;
        end
        if (got.run_end !== want.run_end)
        begin
            $error("run_end: expected %0b, got %0b", want.run_end, got.run_end);
            fail_count++;
        end
    endtask

    initial
    begin
        phase           = SCAN_IDLE;
        held_digit      = 8'h00;
        fail_count      = 0;
        pending_results = 0;
        items_taken     = 0;
        results_checked = 0;
        escapes_decoded = 0;
    end

    // Inputs are predicted before outputs are compared, so a same-edge result
    // always meets the oldest expectation first.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            phase = SCAN_IDLE;
            awaited.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_step(in_data);
                items_taken++;
            end
            if (out_valid && out_ready)
                compare_result(out_data);
        end
        pending_results = awaited.size();
    end

endmodule

/* sim/testbench.sv */
// Stimulus, clocking and verdict for the URL percent decoder testbench.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pud_pkg::*;

    localparam logic [7:0] PERCENT      = 8'h25;
    localparam int         RANDOM_ITEMS = 96;

    logic clk = 1'b0;
    logic rst_n;

    int fail_count;
    int pending_results;
    int items_taken;
    int results_checked;
    int escapes_decoded;

    int         strings_sent;
    bit         no_gaps;
    logic [7:0] str_bytes[$];

    pud_stream_if #(.payload_t(in_item_t))  in_ch();
    pud_stream_if #(.payload_t(out_item_t)) out_ch();

    url_percent_decoder_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    pud_decode_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .in_data         (in_ch.data),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_data        (out_ch.data),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .items_taken     (items_taken),
        .results_checked (results_checked),
        .escapes_decoded (escapes_decoded)
    );

    always #5 clk = ~clk;

    // Idle length: usually none, often short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic bit is_hex_char(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
        if (v < 10) return 8'h30 + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (is_hex_char(b));
        return b;
    endfunction

    // Present one item after an optional gap and hold it until accepted.
    task automatic send_item(logic [7:0] b, logic last);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            in_ch.data  = '0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.data.in_byte = b;
        in_ch.data.is_last = last;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic send_string();
        foreach (str_bytes[i])
            send_item(str_bytes[i], i == str_bytes.size() - 1);
        strings_sent++;
    endtask

    task automatic send_text(string s);
        str_bytes.delete();
        for (int i = 0; i < s.len(); i++)
            str_bytes.push_back(s[i]);
        send_string();
    endtask

    // Hold the sender off until every awaited result has been delivered.
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        while (pending_results != 0) @(negedge clk);
    endtask

    // Build a string from escape-shaped tokens, then cut it to length so that
    // some strings end in the middle of an escape.
    task automatic build_random_string(int target_len);
        int         r;
        logic [7:0] b;
        str_bytes.delete();
        while (str_bytes.size() < target_len)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                do b = 8'($urandom_range(0, 255)); while (b == PERCENT);
                str_bytes.push_back(b);
            end
            else if (r < 62)
            begin
                b = ($urandom_range(0, 9) == 0) ? 8'h7F : 8'($urandom_range(0, 255));
                str_bytes.push_back(PERCENT);
                str_bytes.push_back(hex_char(b[7:4], 1'($urandom_range(0, 1))));
                str_bytes.push_back(hex_char(b[3:0], 1'($urandom_range(0, 1))));
            end
            else if (r < 72)
            begin
                str_bytes.push_back(PERCENT);
                str_bytes.push_back(non_hex_byte());
            end
            else if (r < 82)
            begin
                str_bytes.push_back(PERCENT);
                str_bytes.push_back(hex_char(4'($urandom_range(0, 15)),
                                             1'($urandom_range(0, 1))));
                str_bytes.push_back(non_hex_byte());
            end
            else if (r < 88)
            begin
                str_bytes.push_back(PERCENT);
            end
            else
            begin
                str_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        while (str_bytes.size() > target_len)
            void'(str_bytes.pop_back());
    endtask

    // Receiver: ready runs of random length broken by random stalls.
    initial
    begin
        int run;
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 12);
            @(negedge clk);
            out_ch.ready = 1'b1;
            repeat (run - 1) @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                @(negedge clk);
                out_ch.ready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    // Main stimulus and verdict.
    initial
    begin
        int sent_random;
        int len;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        strings_sent = 0;
        no_gaps      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed strings: byte extremes, decoding, the DEL pass-through,
        // broken escapes and end of string while a '%' or a digit is held.
        str_bytes = {8'h00};
        send_string();
        str_bytes = {8'hFF};
        send_string();
        send_text("%41");
        send_text("%7f");
        send_text("%Fe");
        send_text("%%g");
        send_text("%4z");
        send_text("%");
        send_text("%a");
        send_text("%00");
        wait_drained();

        // Random strings, mostly short; one string in five runs without gaps.
        sent_random = 0;
        while (sent_random < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 16)
                                              : $urandom_range(1, 10);
            build_random_string(len);
            no_gaps = ($urandom_range(0, 4) == 0);
            send_string();
            sent_random += len;
            if (sent_random >= RANDOM_ITEMS / 2 && sent_random - len < RANDOM_ITEMS / 2)
                wait_drained();
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);

        $display("Run covered %0d strings and %0d input items; %0d result items compared.",
                 strings_sent, items_taken, results_checked);
        $display("Escapes decoded to single bytes: %0d.", escapes_decoded);
        if (fail_count == 0 && pending_results == 0)
            $display("** url_percent_decoder_top: PASSED **");
        else
            $display("** url_percent_decoder_top: FAILED **");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still awaited.", pending_results);
        $display("** url_percent_decoder_top: FAILED **");
        $finish;
    end

endmodule
